@@ src/mrr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared types, constants and the CRC-16 byte update for the register reader.
// ----------------------------------------------------------------------------
package mrr_pkg;

  // words kept from one reply
  localparam int MaxWords = 20;
  localparam int AddrW    = $clog2(MaxWords);
  localparam int WordCntW = $clog2(MaxWords + 1);
  // reply byte position runs up to 3 + 2*MaxWords + 1
  localparam int PosW     = $clog2(3 + 2 * MaxWords + 2);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [6:0]  FuncCodeReset = 7'd4;
  localparam logic [15:0] RegLimitReset = 16'd400;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_READ    = 2'd2,
    KIND_TIMEOUT = 2'd3
  } mrr_kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TIMEOUT = 3'd1,
    ST_CRC     = 3'd2,
    ST_NODE    = 3'd3,
    ST_FUNC    = 3'd4,
    ST_MISS    = 3'd5,
    ST_BUSY    = 3'd6
  } mrr_status_e;

  typedef enum logic {
    CFG_FUNCTION_CODE  = 1'b0,
    CFG_REGISTER_LIMIT = 1'b1
  } mrr_cfg_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_TX   = 2'd1,
    S_READ = 2'd2
  } mrr_state_e;

  typedef struct packed {
    mrr_kind_e   kind;
    logic [7:0]  node;
    logic [15:0] register_address;
    logic [7:0]  rx_byte;
    logic        two_words;
  } mrr_in_t;

  typedef struct packed {
    logic        is_tx;
    logic [7:0]  tx_byte;
    logic        last;
    mrr_status_e status;
    logic [31:0] value;
    logic [15:0] error_count;
    logic [15:0] success_count;
  } mrr_out_t;

  // word store access for one cycle
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [15:0]      wdata;
    logic             re;
    logic [AddrW-1:0] raddr0;
    logic [AddrW-1:0] raddr1;
  } mrr_mem_req_t;

  // reflected crc-16, one byte
  function automatic logic [15:0] mrr_crc_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ src/mrr_word_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrr_word_store
// Reply data words: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mrr_word_store
  import mrr_pkg::*;
(
  input  wire logic         clk_i,
  input  wire mrr_mem_req_t req_i,
  output logic [15:0]       rd0_o,
  output logic [15:0]       rd1_o
);

  logic [15:0] mem_q [MaxWords];
  logic [15:0] rd0_q;
  logic [15:0] rd1_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd0_q <= mem_q[req_i.raddr0];
      rd1_q <= mem_q[req_i.raddr1];
    end
  end

  assign rd0_o = rd0_q;
  assign rd1_o = rd1_q;

endmodule
`default_nettype wire

@@ src/modbus_rtu_register_reader.sv @@
// Timing: a received byte or a timeout is handled in its accept cycle; a cache read
// that hits loads after one word store read; other results load in the accept cycle.
// A start request is accepted, then sends one request byte per cycle while the output
// slot is free, with the crc built one byte per cycle by the shared byte-wide crc unit.
// Reset clears control state and counters, sets function code 4 and limit 400;
// the word store is not cleared, so no clearing pass follows reset.
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_register_reader
// Serial-line master for register reads: sends the read request, checks the
// reply, keeps the data words in a small store and answers cached reads.
// ----------------------------------------------------------------------------
module modbus_rtu_register_reader
  import mrr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire mrr_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output mrr_out_t         out_data_o,
  input  wire logic        cfg_we_i,
  input  wire mrr_cfg_e    cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  mrr_state_e  state_q, state_d;
  logic [6:0]  fc_q;
  logic [15:0] limit_q;
  logic        busy_q, busy_d;
  logic        cache_valid_q, cache_valid_d;
  logic [7:0]  target_node_q, target_node_d;
  logic [15:0] start_reg_q, start_reg_d;
  logic [WordCntW-1:0] word_count_q, word_count_d;
  logic [PosW-1:0]     byte_pos_q, byte_pos_d;
  logic [15:0] crc_q, crc_d;
  mrr_status_e frame_status_q, frame_status_d;
  logic [7:0]  crc_low_q, crc_low_d;
  logic [7:0]  hi_byte_q, hi_byte_d;
  logic [15:0] fail_q, fail_d;
  logic [15:0] ok_q, ok_d;
  logic [2:0]  tx_idx_q, tx_idx_d;
  logic        two_q, two_d;
  logic        out_valid_q, out_valid_d;
  mrr_out_t    out_q, out_d;

  mrr_mem_req_t mem_req;
  logic [15:0]  rd0;
  logic [15:0]  rd1;

  logic            out_free;
  logic            accept;
  logic [7:0]      crc_in_byte;
  logic [15:0]     crc_next;
  logic [7:0]      tx_byte_sel;
  logic [15:0]     count16;
  logic [15:0]     lim_diff;
  logic [PosW-1:0] data_end;
  logic [PosW-1:0] wr_off;
  logic [16:0]     rd_off;
  logic [17:0]     rd_end;
  logic            rd_hit;
  logic            load;
  mrr_status_e     load_status;
  logic            load_tx;
  logic            load_last;
  logic [7:0]      load_byte;
  logic [31:0]     load_value;

  // word store
  mrr_word_store u_store (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rd0_o (rd0),
    .rd1_o (rd1)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q    <= FuncCodeReset;
      limit_q <= RegLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FUNCTION_CODE:  fc_q    <= cfg_data_i[6:0];
        CFG_REGISTER_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request frame byte and shared crc unit
  assign count16 = 16'(word_count_q);
  always_comb begin
    case (tx_idx_q)
      3'd0:    tx_byte_sel = target_node_q;
      3'd1:    tx_byte_sel = {1'b0, fc_q};
      3'd2:    tx_byte_sel = start_reg_q[15:8];
      3'd3:    tx_byte_sel = start_reg_q[7:0];
      3'd4:    tx_byte_sel = count16[15:8];
      3'd5:    tx_byte_sel = count16[7:0];
      3'd6:    tx_byte_sel = crc_q[7:0];
      default: tx_byte_sel = crc_q[15:8];
    endcase
  end

  assign crc_in_byte = (state_q == S_TX) ? tx_byte_sel : in_data_i.rx_byte;
  assign crc_next    = mrr_crc_byte(crc_q, crc_in_byte);

  // reply and read address arithmetic
  assign lim_diff = limit_q - in_data_i.register_address;
  assign data_end = PosW'(3) + PosW'({word_count_q, 1'b0});
  assign wr_off   = byte_pos_q - PosW'(3);
  assign rd_off   = {1'b0, in_data_i.register_address} - {1'b0, start_reg_q};
  assign rd_end   = {1'b0, rd_off} + (in_data_i.two_words ? 18'd2 : 18'd1);
  // word_count never exceeds MaxWords, so this bound covers the store too
  assign rd_hit   = cache_valid_q && (in_data_i.node == target_node_q) &&
                    !rd_off[16] && (rd_end <= 18'(word_count_q));

  // handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  // next state and datapath
  always_comb begin
    state_d        = state_q;
    busy_d         = busy_q;
    cache_valid_d  = cache_valid_q;
    target_node_d  = target_node_q;
    start_reg_d    = start_reg_q;
    word_count_d   = word_count_q;
    byte_pos_d     = byte_pos_q;
    crc_d          = crc_q;
    frame_status_d = frame_status_q;
    crc_low_d      = crc_low_q;
    hi_byte_d      = hi_byte_q;
    fail_d         = fail_q;
    ok_d           = ok_q;
    tx_idx_d       = tx_idx_q;
    two_d          = two_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    out_d          = out_q;
    mem_req        = '0;
    load           = 1'b0;
    load_status    = ST_OK;
    load_tx        = 1'b0;
    load_last      = 1'b1;
    load_byte      = 8'h00;
    load_value     = 32'h0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data_i.kind)
            KIND_START: begin
              if (busy_q) begin
                load        = 1'b1;
                load_status = ST_BUSY;
              end else begin
                busy_d         = 1'b1;
                cache_valid_d  = 1'b0;
                target_node_d  = in_data_i.node;
                start_reg_d    = in_data_i.register_address;
                word_count_d   = (lim_diff > 16'(MaxWords)) ? WordCntW'(MaxWords)
                                                            : lim_diff[WordCntW-1:0];
                byte_pos_d     = '0;
                crc_d          = CrcInit;
                frame_status_d = ST_OK;
                tx_idx_d       = 3'd0;
                state_d        = S_TX;
              end
            end
            KIND_BYTE: begin
              if (busy_q) begin
                if (byte_pos_q < data_end) begin
                  // header and data bytes feed the crc
                  crc_d      = crc_next;
                  byte_pos_d = byte_pos_q + PosW'(1);
                  if (byte_pos_q == PosW'(0) && in_data_i.rx_byte != target_node_q &&
                      frame_status_q == ST_OK) begin
                    frame_status_d = ST_NODE;
                  end
                  if (byte_pos_q == PosW'(1) && in_data_i.rx_byte != {1'b0, fc_q} &&
                      frame_status_q == ST_OK) begin
                    frame_status_d = ST_FUNC;
                  end
                  if (byte_pos_q >= PosW'(3)) begin
                    if (!wr_off[0]) begin
                      hi_byte_d = in_data_i.rx_byte;
                    end else begin
                      mem_req.we    = 1'b1;
                      mem_req.waddr = AddrW'(wr_off >> 1);
                      mem_req.wdata = {hi_byte_q, in_data_i.rx_byte};
                    end
                  end
                end else if (byte_pos_q == data_end) begin
                  crc_low_d  = in_data_i.rx_byte;
                  byte_pos_d = byte_pos_q + PosW'(1);
                end else begin
                  // end of reply: node, function, then crc
                  load_status = frame_status_q;
                  if (frame_status_q == ST_OK &&
                      {in_data_i.rx_byte, crc_low_q} != crc_q) begin
                    load_status = ST_CRC;
                  end
                  load           = 1'b1;
                  busy_d         = 1'b0;
                  byte_pos_d     = '0;
                  crc_d          = CrcInit;
                  frame_status_d = ST_OK;
                  if (load_status == ST_OK) begin
                    ok_d          = ok_q + 16'd1;
                    cache_valid_d = 1'b1;
                  end else begin
                    fail_d        = fail_q + 16'd1;
                    cache_valid_d = 1'b0;
                  end
                end
              end
            end
            KIND_READ: begin
              if (busy_q) begin
                load        = 1'b1;
                load_status = ST_BUSY;
              end else if (rd_hit) begin
                mem_req.re     = 1'b1;
                mem_req.raddr0 = rd_off[AddrW-1:0];
                mem_req.raddr1 = rd_off[AddrW-1:0] + AddrW'(1);
                two_d          = in_data_i.two_words;
                state_d        = S_READ;
              end else begin
                load        = 1'b1;
                load_status = ST_MISS;
              end
            end
            KIND_TIMEOUT: begin
              if (busy_q) begin
                busy_d         = 1'b0;
                cache_valid_d  = 1'b0;
                byte_pos_d     = '0;
                crc_d          = CrcInit;
                frame_status_d = ST_OK;
                fail_d         = fail_q + 16'd1;
                load           = 1'b1;
                load_status    = ST_TIMEOUT;
              end
            end
            default: ;
          endcase
        end
      end
      S_TX: begin
        // one request byte per transfer slot
        if (out_free) begin
          load      = 1'b1;
          load_tx   = 1'b1;
          load_byte = tx_byte_sel;
          load_last = (tx_idx_q == 3'd7);
          tx_idx_d  = tx_idx_q + 3'd1;
          if (tx_idx_q < 3'd6) begin
            crc_d = crc_next;
          end
          if (tx_idx_q == 3'd7) begin
            crc_d   = CrcInit;
            state_d = S_IDLE;
          end
        end
      end
      S_READ: begin
        // output slot was freed when the read was accepted
        load       = 1'b1;
        load_value = two_q ? {rd0, rd1} : {16'h0000, rd0};
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (load) begin
      out_valid_d         = 1'b1;
      out_d.is_tx         = load_tx;
      out_d.tx_byte       = load_byte;
      out_d.last          = load_last;
      out_d.status        = load_status;
      out_d.value         = load_value;
      out_d.error_count   = fail_d;
      out_d.success_count = ok_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      busy_q         <= 1'b0;
      cache_valid_q  <= 1'b0;
      word_count_q   <= '0;
      byte_pos_q     <= '0;
      crc_q          <= CrcInit;
      frame_status_q <= ST_OK;
      fail_q         <= 16'h0000;
      ok_q           <= 16'h0000;
      tx_idx_q       <= 3'd0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      busy_q         <= busy_d;
      cache_valid_q  <= cache_valid_d;
      word_count_q   <= word_count_d;
      byte_pos_q     <= byte_pos_d;
      crc_q          <= crc_d;
      frame_status_q <= frame_status_d;
      fail_q         <= fail_d;
      ok_q           <= ok_d;
      tx_idx_q       <= tx_idx_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    target_node_q <= target_node_d;
    start_reg_q   <= start_reg_d;
    crc_low_q     <= crc_low_d;
    hi_byte_q     <= hi_byte_d;
    two_q         <= two_d;
    out_q         <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // request bytes only go out for a transaction in flight
  a_tx_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TX |-> busy_q)
    else $error("request frame sent while not busy");

  // a cache read lands in an empty output slot
  a_read_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> !out_valid_q)
    else $error("read result would overwrite a pending result");

  // word store is written only while a reply is in progress
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> busy_q && state_q == S_IDLE)
    else $error("word store written outside a reply");

  // reply position never runs past the crc bytes
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> byte_pos_q <= data_end + PosW'(1))
    else $error("reply position out of range");

  // counters move by at most one per cycle and never together
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fail_q != $past(fail_q)) |-> (ok_q == $past(ok_q)))
    else $error("both counters changed in one cycle");
`endif

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the register reader: drives request, reply-byte,
// cache-read and timeout items with random bursts and output stalls, predicts
// every request frame byte and status, and compares each result field.
// ----------------------------------------------------------------------------
module tb
  import mrr_pkg::*;
();

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 20;
  localparam int PhaseItems    = 36;

  typedef enum int {
    FLAW_NONE,
    FLAW_CRC,
    FLAW_LEN,
    FLAW_CUT,
    FLAW_INTRUDE
  } reply_flaw_e;

  typedef enum int {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_PATTERN,
    READY_COIN
  } ready_mode_e;

  // predicted reader state plus the queue of results still to arrive
  class reader_scoreboard;
    logic [6:0]  func_code = FuncCodeReset;
    logic [15:0] reg_limit = RegLimitReset;
    logic [15:0] words [MaxWords];
    bit          cache_ok = 1'b0;
    bit          awaiting_reply = 1'b0;
    logic [7:0]  tgt_node = '0;
    logic [15:0] base_reg = '0;
    int unsigned n_words = 0;
    int unsigned rx_pos = 0;
    logic [15:0] crc_acc = CrcInit;
    mrr_status_e frame_err = ST_OK;
    logic [7:0]  crc_lo = '0;
    logic [15:0] fail_cnt = '0;
    logic [15:0] ok_cnt = '0;
    mrr_out_t    pending [$];
    int unsigned errors = 0;
    int unsigned results_seen = 0;
    int unsigned frames_sent = 0;
    int unsigned replies_ok = 0;
    int unsigned replies_bad = 0;
    int unsigned aborts = 0;
    int unsigned cache_hits = 0;
    int unsigned cache_misses = 0;
    int unsigned busy_rejects = 0;

    function new();
      foreach (words[i]) words[i] = '0;
    endfunction

    // bit-serial form of the reflected crc-16
    static function logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c = c >> 1;
        if (fb) c = c ^ CrcPoly;
      end
      return c;
    endfunction

    function void push_result(bit tx, logic [7:0] b, bit lst, mrr_status_e st,
                              logic [31:0] v);
      mrr_out_t r;
      r.is_tx         = tx;
      r.tx_byte       = b;
      r.last          = lst;
      r.status        = st;
      r.value         = v;
      r.error_count   = fail_cnt;
      r.success_count = ok_cnt;
      pending.push_back(r);
    endfunction

    // note one accepted input item; returns 0 when the block ignores it
    function bit note_item(mrr_in_t it);
      logic [15:0] cnt16;
      logic [7:0]  frame [8];
      logic [15:0] crc;
      logic [15:0] got;
      int unsigned data_end;
      int unsigned need;
      int unsigned off;
      int unsigned w;
      mrr_status_e st;
      bit          hit;
      case (it.kind)
        KIND_START: begin
          if (awaiting_reply) begin
            push_result(1'b0, 8'h00, 1'b1, ST_BUSY, 32'd0);
            busy_rejects++;
            return 1'b1;
          end
          cnt16 = reg_limit - it.register_address;
          if (cnt16 > 16'(MaxWords)) cnt16 = 16'(MaxWords);
          awaiting_reply = 1'b1;
          cache_ok       = 1'b0;
          tgt_node       = it.node;
          base_reg       = it.register_address;
          n_words        = cnt16;
          rx_pos         = 0;
          crc_acc        = CrcInit;
          frame_err      = ST_OK;
          frame[0] = it.node;
          frame[1] = {1'b0, func_code};
          frame[2] = it.register_address[15:8];
          frame[3] = it.register_address[7:0];
          frame[4] = cnt16[15:8];
          frame[5] = cnt16[7:0];
          crc = CrcInit;
          for (int i = 0; i < 6; i++) crc = crc16_update(crc, frame[i]);
          frame[6] = crc[7:0];
          frame[7] = crc[15:8];
          for (int i = 0; i < 8; i++) push_result(1'b1, frame[i], i == 7, ST_OK, 32'd0);
          frames_sent++;
          return 1'b1;
        end
        KIND_BYTE: begin
          if (!awaiting_reply) return 1'b0;
          data_end = 3 + 2 * n_words;
          if (rx_pos < data_end) begin
            crc_acc = crc16_update(crc_acc, it.rx_byte);
            if (rx_pos == 0 && it.rx_byte != tgt_node && frame_err == ST_OK)
              frame_err = ST_NODE;
            if (rx_pos == 1 && it.rx_byte != {1'b0, func_code} && frame_err == ST_OK)
              frame_err = ST_FUNC;
            // data words arrive high byte first
            if (rx_pos >= 3) begin
              w = (rx_pos - 3) >> 1;
              if (((rx_pos - 3) & 1) == 0) words[w][15:8] = it.rx_byte;
              else words[w][7:0] = it.rx_byte;
            end
            rx_pos++;
          end else if (rx_pos == data_end) begin
            crc_lo = it.rx_byte;
            rx_pos++;
          end else begin
            got = {it.rx_byte, crc_lo};
            st  = frame_err;
            if (st == ST_OK && got != crc_acc) st = ST_CRC;
            awaiting_reply = 1'b0;
            rx_pos         = 0;
            crc_acc        = CrcInit;
            frame_err      = ST_OK;
            if (st == ST_OK) begin
              ok_cnt   = ok_cnt + 16'd1;
              cache_ok = 1'b1;
              replies_ok++;
            end else begin
              fail_cnt = fail_cnt + 16'd1;
              cache_ok = 1'b0;
              replies_bad++;
            end
            push_result(1'b0, 8'h00, 1'b1, st, 32'd0);
          end
          return 1'b1;
        end
        KIND_READ: begin
          if (awaiting_reply) begin
            push_result(1'b0, 8'h00, 1'b1, ST_BUSY, 32'd0);
            busy_rejects++;
            return 1'b1;
          end
          need = it.two_words ? 2 : 1;
          hit  = 1'b0;
          off  = 0;
          if (cache_ok && it.node == tgt_node && it.register_address >= base_reg) begin
            off = it.register_address - base_reg;
            hit = (off + need <= n_words) && (off + need <= MaxWords);
          end
          if (!hit) begin
            push_result(1'b0, 8'h00, 1'b1, ST_MISS, 32'd0);
            cache_misses++;
          end else begin
            if (it.two_words)
              push_result(1'b0, 8'h00, 1'b1, ST_OK, {words[off], words[off + 1]});
            else
              push_result(1'b0, 8'h00, 1'b1, ST_OK, {16'h0000, words[off]});
            cache_hits++;
          end
          return 1'b1;
        end
        default: begin
          if (!awaiting_reply) return 1'b0;
          awaiting_reply = 1'b0;
          cache_ok       = 1'b0;
          rx_pos         = 0;
          crc_acc        = CrcInit;
          frame_err      = ST_OK;
          fail_cnt       = fail_cnt + 16'd1;
          aborts++;
          push_result(1'b0, 8'h00, 1'b1, ST_TIMEOUT, 32'd0);
          return 1'b1;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      end
    endfunction

    // compare one output transfer against the oldest prediction
    function void check_result(mrr_out_t got);
      mrr_out_t exp;
      results_seen++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual %h", $time, got);
        return;
      end
      exp = pending.pop_front();
      compare_field("is_tx", exp.is_tx, got.is_tx);
      compare_field("tx_byte", exp.tx_byte, got.tx_byte);
      compare_field("last", exp.last, got.last);
      compare_field("status", exp.status, got.status);
      compare_field("value", exp.value, got.value);
      compare_field("error_count", exp.error_count, got.error_count);
      compare_field("success_count", exp.success_count, got.success_count);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  mrr_in_t     in_data = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  mrr_out_t    out_data;
  logic        cfg_we = 1'b0;
  mrr_cfg_e    cfg_index = CFG_FUNCTION_CODE;
  logic [15:0] cfg_data = '0;

  reader_scoreboard sb;
  int unsigned      burst_left = 0;
  int unsigned      gap_max = 0;
  int unsigned      work_items = 0;
  int unsigned      quiet_cycles = 0;
  ready_mode_e      ready_mode = READY_ALWAYS;
  logic [7:0]       stall_pattern = 8'b1101_0110;
  logic [15:0]      reply_words [$];

  modbus_rtu_register_reader dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver stalls
  always @(posedge clk_i) begin
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
      READY_PATTERN: begin
        out_ready     <= stall_pattern[0];
        stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
      end
      default: out_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  // output transfer check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_result(out_data);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input transfer, with bursts and random gaps
  task automatic send_item(input mrr_in_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
    if (sb.note_item(it)) work_items++;
  endtask

  task automatic send_kind(input mrr_kind_e k, input logic [7:0] nd,
                           input logic [15:0] ra, input logic [7:0] rx,
                           input logic two);
    mrr_in_t it;
    it.kind             = k;
    it.node             = nd;
    it.register_address = ra;
    it.rx_byte          = rx;
    it.two_words        = two;
    send_item(it);
  endtask

  // reply frame built from reply_words, optionally damaged
  task automatic send_reply(input logic [7:0] nd, input logic [7:0] fn,
                            input reply_flaw_e flaw);
    logic [7:0]  frame_bytes [$];
    logic [15:0] crc;
    int unsigned cut;
    int unsigned intrude_at;
    frame_bytes.push_back(nd);
    frame_bytes.push_back(fn);
    frame_bytes.push_back(flaw == FLAW_LEN ? 8'($urandom) : 8'(2 * reply_words.size()));
    foreach (reply_words[i]) begin
      frame_bytes.push_back(reply_words[i][15:8]);
      frame_bytes.push_back(reply_words[i][7:0]);
    end
    crc = CrcInit;
    foreach (frame_bytes[i]) crc = reader_scoreboard::crc16_update(crc, frame_bytes[i]);
    if (flaw == FLAW_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
    cut        = (flaw == FLAW_CUT) ? $urandom_range(0, frame_bytes.size() - 1)
                                    : frame_bytes.size();
    intrude_at = (flaw == FLAW_INTRUDE) ? $urandom_range(0, frame_bytes.size() - 1)
                                        : frame_bytes.size();
    for (int i = 0; i < cut; i++) begin
      if (i == intrude_at)
        send_kind($urandom_range(0, 1) ? KIND_START : KIND_READ, 8'($urandom),
                  16'($urandom), 8'($urandom), 1'($urandom));
      send_kind(KIND_BYTE, 8'($urandom), 16'($urandom), frame_bytes[i], 1'($urandom));
    end
    if (flaw == FLAW_CUT)
      send_kind(KIND_TIMEOUT, 8'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // cached reads around the words of the last request
  task automatic cache_reads(input logic [7:0] nd, input logic [15:0] base,
                             input int unsigned cnt);
    int unsigned off;
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 3) != 0) begin
        off = (cnt == 0) ? 0 : $urandom_range(0, cnt - 1);
        send_kind(KIND_READ, nd, base + 16'(off), 8'($urandom), 1'($urandom));
      end else begin
        send_kind(KIND_READ, 8'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // request, reply (mostly clean) and a few reads
  task automatic random_exchange();
    logic [7:0]  nd;
    logic [7:0]  hdr_node;
    logic [7:0]  hdr_func;
    logic [15:0] ra;
    int unsigned cnt;
    int unsigned pick;
    reply_flaw_e flaw;
    if (sb.awaiting_reply)
      send_kind(KIND_TIMEOUT, 8'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
    nd = 8'($urandom);
    // small counts mostly, landing just below the limit
    if ($urandom_range(0, 9) < 8) ra = sb.reg_limit - 16'($urandom_range(0, 4));
    else ra = 16'($urandom);
    send_kind(KIND_START, nd, ra, 8'($urandom), 1'($urandom));
    cnt = sb.n_words;
    reply_words.delete();
    repeat (cnt) reply_words.push_back(16'($urandom));
    hdr_node = nd;
    hdr_func = {1'b0, sb.func_code};
    flaw     = FLAW_NONE;
    pick     = $urandom_range(0, 19);
    case (pick)
      12: hdr_node = nd ^ 8'($urandom_range(1, 255));
      13: hdr_func = hdr_func ^ 8'($urandom_range(1, 255));
      14: flaw = FLAW_CRC;
      15: flaw = FLAW_LEN;
      16: flaw = FLAW_CUT;
      17: flaw = FLAW_INTRUDE;
      18: begin
        hdr_node = nd ^ 8'($urandom_range(1, 255));
        flaw     = FLAW_CRC;
      end
      default: ;
    endcase
    // pick 19 leaves the request unanswered so the reads see a busy block
    if (pick != 19) send_reply(hdr_node, hdr_func, flaw);
    cache_reads(nd, ra, cnt);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 3))
      send_kind(mrr_kind_e'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                8'($urandom), 1'($urandom));
  endtask

  // drop valid and let every outstanding result drain
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [6:0] fc, input logic [15:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FUNCTION_CODE;
    cfg_data  <= {9'd0, fc};
    @(posedge clk_i);
    sb.func_code = fc;
    cfg_index <= CFG_REGISTER_LIMIT;
    cfg_data  <= lim;
    @(posedge clk_i);
    sb.reg_limit = lim;
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned phase_base;
    logic [6:0]  fc;
    logic [15:0] lim;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset configuration, no idling
    gap_max    = 0;
    ready_mode = READY_ALWAYS;
    send_kind(KIND_READ, 8'h00, 16'h0000, 8'h00, 1'b0);      // nothing cached yet
    send_kind(KIND_BYTE, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);      // ignored while idle
    send_kind(KIND_TIMEOUT, 8'h00, 16'h0000, 8'h00, 1'b0);   // ignored while idle
    send_kind(KIND_START, 8'hFF, 16'd400, 8'h00, 1'b0);      // zero-length request
    send_kind(KIND_START, 8'h12, 16'h0001, 8'h00, 1'b0);     // refused, busy
    send_kind(KIND_READ, 8'hFF, 16'd400, 8'h00, 1'b1);       // refused, busy
    reply_words.delete();
    send_reply(8'hFF, {1'b0, sb.func_code}, FLAW_NONE);
    send_kind(KIND_READ, 8'hFF, 16'd400, 8'h00, 1'b0);       // no words to hit
    send_kind(KIND_START, 8'h00, 16'hFFFF, 8'h00, 1'b0);     // count wraps, capped
    send_kind(KIND_TIMEOUT, 8'hFF, 16'h0000, 8'h00, 1'b1);   // abort
    send_kind(KIND_START, 8'h5A, 16'd398, 8'h00, 1'b0);
    reply_words = '{16'hFFFF, 16'h0000};
    send_reply(8'h5A, {1'b0, sb.func_code}, FLAW_NONE);
    send_kind(KIND_READ, 8'h5A, 16'd398, 8'h00, 1'b0);
    send_kind(KIND_READ, 8'h5A, 16'd398, 8'h00, 1'b1);
    send_kind(KIND_READ, 8'h5A, 16'd399, 8'h00, 1'b1);       // runs past the words
    send_kind(KIND_READ, 8'h5A, 16'd397, 8'h00, 1'b0);       // below the start
    send_kind(KIND_READ, 8'h5B, 16'd399, 8'h00, 1'b0);       // other node
    // wrong node and bad crc together: node is reported
    send_kind(KIND_START, 8'h33, 16'd399, 8'h00, 1'b0);
    reply_words = '{16'h1234};
    send_reply(8'h34, {1'b0, sb.func_code}, FLAW_CRC);

    // random phases over several configurations
    for (int p = 0; p < 4; p++) begin
      if (sb.awaiting_reply)
        send_kind(KIND_TIMEOUT, 8'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
      settle();
      case (p)
        0: begin
          fc = 7'd127; lim = 16'hFFFF; gap_max = 3; ready_mode = READY_MOSTLY;
        end
        1: begin
          fc = 7'd1; lim = 16'd1; gap_max = 0; ready_mode = READY_PATTERN;
        end
        2: begin
          fc = 7'($urandom_range(1, 127)); lim = 16'($urandom_range(1, 65535));
          gap_max = 5; ready_mode = READY_COIN;
        end
        default: begin
          fc = 7'($urandom_range(1, 127)); lim = 16'($urandom_range(1, 65535));
          gap_max = 2; ready_mode = READY_ALWAYS;
        end
      endcase
      write_config(fc, lim);
      phase_base = work_items;
      while (work_items - phase_base < PhaseItems) begin
        if ($urandom_range(0, 9) < 8) random_exchange();
        else noise_burst();
      end
    end
    settle();

    $display("%0d items, %0d request frames, replies %0d good / %0d bad, %0d aborted",
             work_items, sb.frames_sent, sb.replies_ok, sb.replies_bad, sb.aborts);
    $display("cache reads %0d hit / %0d miss, %0d busy refusals, %0d results checked",
             sb.cache_hits, sb.cache_misses, sb.busy_rejects, sb.results_seen);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
src/mrr_pkg.sv
src/mrr_word_store.sv
src/modbus_rtu_register_reader.sv
tb/tb.sv
